// ===== hw/rtl/bnf_pkg.sv =====
// ----------------------------------------------------------------------------
// bnf_pkg
// Shared types, constants and the delay-line saturation helper for the
// biquad notch filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bnf_pkg;

    localparam int DELAY_BITS    = 40;
    localparam int GAIN_BITS     = 16;
    localparam int GAIN_FRAC     = 14;
    localparam int ACC_SPLIT     = 20;   // acc is multiplied by gain in two halves
    localparam int GACC_BITS     = DELAY_BITS + GAIN_BITS + 2;
    localparam int CFG_ADDR_BITS = 3;

    localparam logic signed [63:0] DELAY_MAX = (64'sd1 <<< (DELAY_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] DELAY_MIN = -DELAY_MAX - 64'sd1;

    typedef logic signed [DELAY_BITS-1:0] delay_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_B0   = 3'd0,
        REG_B1   = 3'd1,
        REG_B2   = 3'd2,
        REG_A1   = 3'd3,
        REG_A2   = 3'd4,
        REG_GAIN = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_Y,
        ST_A1,
        ST_T1A,
        ST_T2A,
        ST_T1D,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_B0X,
        MUL_B1X,
        MUL_B2X,
        MUL_A1Y,
        MUL_A2Y,
        MUL_GLO,
        MUL_GHI
    } mul_op_t;

    typedef enum logic [2:0] {
        ADD_NONE,
        ADD_ACC,
        ADD_YRND,
        ADD_T1A,
        ADD_T2A,
        ADD_T1D
    } add_op_t;

    typedef struct packed {
        logic    mul_en;
        mul_op_t mul_op;
        add_op_t add_op;
        logic    ld_t1_prod;
        logic    ld_t2_prod;
        logic    ld_gacc;
        logic    commit;
    } ctrl_t;

    // clamp a sign-extended value into the 40-bit delay range
    function automatic delay_t sat_delay(input logic signed [63:0] v);
        delay_t r;
        if (v > DELAY_MAX) begin
            r = DELAY_BITS'(DELAY_MAX);
        end else if (v < DELAY_MIN) begin
            r = DELAY_BITS'(DELAY_MIN);
        end else begin
            r = DELAY_BITS'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bnf_mul.sv =====
// ----------------------------------------------------------------------------
// bnf_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module bnf_mul #(
    parameter int A_BITS = 21,
    parameter int B_BITS = 17
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [A_BITS-1:0]         op_a,
    input  logic signed [B_BITS-1:0]         op_b,
    output logic signed [A_BITS+B_BITS-1:0]  prod
);

    logic signed [A_BITS+B_BITS-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bnf_add.sv =====
// ----------------------------------------------------------------------------
// bnf_add
// Shared 41-bit add/subtract with a raw and a delay-saturated result.
// ----------------------------------------------------------------------------
`default_nettype none

module bnf_add (
    input  logic                                op_sub,
    input  bnf_pkg::delay_t                     op_a,
    input  bnf_pkg::delay_t                     op_b,
    output logic signed [bnf_pkg::DELAY_BITS:0] sum_raw,
    output bnf_pkg::delay_t                     sum_sat
);

    import bnf_pkg::*;

    logic signed [DELAY_BITS:0] a_ext;
    logic signed [DELAY_BITS:0] b_ext;

    assign a_ext   = (DELAY_BITS + 1)'(op_a);
    assign b_ext   = (DELAY_BITS + 1)'(op_b);
    assign sum_raw = op_sub ? (a_ext - b_ext) : (a_ext + b_ext);
    assign sum_sat = sat_delay(64'(sum_raw));

endmodule

`default_nettype wire

// ===== hw/rtl/bnf_seq.sv =====
// ----------------------------------------------------------------------------
// bnf_seq
// Sequencer: walks one sample through the shared multiplier and adder.
// ----------------------------------------------------------------------------
`default_nettype none

module bnf_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            out_busy,
    output logic            s_ready,
    output bnf_pkg::ctrl_t  ctrl
);

    import bnf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        ctrl        = '0;
        ctrl.mul_op = MUL_B0X;
        ctrl.add_op = ADD_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.mul_en = 1'b1;
                    ctrl.mul_op = MUL_B0X;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC: begin
                ctrl.add_op = ADD_ACC;
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = MUL_B1X;
                state_next  = ST_Y;
            end
            ST_Y: begin
                ctrl.add_op     = ADD_YRND;
                ctrl.ld_t1_prod = 1'b1;
                ctrl.mul_en     = 1'b1;
                ctrl.mul_op     = MUL_B2X;
                state_next      = ST_A1;
            end
            ST_A1: begin
                ctrl.ld_t2_prod = 1'b1;
                ctrl.mul_en     = 1'b1;
                ctrl.mul_op     = MUL_A1Y;
                state_next      = ST_T1A;
            end
            ST_T1A: begin
                ctrl.add_op = ADD_T1A;
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = MUL_A2Y;
                state_next  = ST_T2A;
            end
            ST_T2A: begin
                ctrl.add_op = ADD_T2A;
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = MUL_GLO;
                state_next  = ST_T1D;
            end
            ST_T1D: begin
                ctrl.add_op  = ADD_T1D;
                ctrl.ld_gacc = 1'b1;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_op  = MUL_GHI;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (!out_busy) begin
                    ctrl.commit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/biquad_notch_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_notch_filter
// One-channel second-order IIR section (transposed direct form II) with
// output gain, built around one shared multiplier and one shared adder.
// ----------------------------------------------------------------------------
// A sample beat passes the sequencer states ACC, Y, A1, T1A, T2A, T1D and
// OUT before its result beat; the block takes the next sample only once it
// is back in idle, so a new sample waits until the last one is through.
// The pace is set by the shared multiplier: seven products per sample
// (b0*x, b1*x, b2*x, a1*y, a2*y and acc*gain in two halves), one per cycle,
// plus a final step that sums and saturates the output. A result waiting
// in the output register does not block the next sample; only when the
// next result is ready while the previous one is still untaken does the
// sequencer hold in its last step. Coefficients are signed Q3.14 (for the
// default COEF_BITS), gain is unsigned Q2.14, samples are signed Q1.15.
// Write registers only while the block is idle. Register indexes:
// 0 b0, 1 b1, 2 b2, 3 a1, 4 a2, 5 gain; other indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_notch_filter #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // configuration write port
    input  logic                                     cfg_we,
    input  logic [bnf_pkg::CFG_ADDR_BITS-1:0]        cfg_addr,
    input  logic [((COEF_BITS > bnf_pkg::GAIN_BITS) ?
                   COEF_BITS : bnf_pkg::GAIN_BITS)-1:0] cfg_wdata,
    // sample input
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [SAMPLE_BITS-1:0]            s_sample_in,
    // filtered output
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [SAMPLE_BITS-1:0]            m_sample_out
);

    import bnf_pkg::*;

    localparam int COEF_FRAC  = COEF_BITS - 4;
    localparam int OUT_SHIFT  = COEF_FRAC + GAIN_FRAC;
    localparam int MUL_A_BITS = (COEF_BITS > ACC_SPLIT + 1) ? COEF_BITS : ACC_SPLIT + 1;
    localparam int MUL_B_BITS = (SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

    // rounding halves and saturation limits
    localparam delay_t Y_HALF = DELAY_BITS'(64'sd1 <<< (COEF_FRAC - 1));
    localparam logic signed [DELAY_BITS:0] Y_MAX =
        (DELAY_BITS + 1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [DELAY_BITS:0] Y_MIN =
        (DELAY_BITS + 1)'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [GACC_BITS-1:0] G_HALF =
        GACC_BITS'(64'sd1 <<< (OUT_SHIFT - 1));
    localparam logic signed [GACC_BITS-1:0] O_MAX =
        GACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [GACC_BITS-1:0] O_MIN =
        GACC_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(64'sd1 <<< COEF_FRAC);
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(64'd1 << GAIN_FRAC);

    // configuration
    logic signed [COEF_BITS-1:0] coef_b0_reg;
    logic signed [COEF_BITS-1:0] coef_b1_reg;
    logic signed [COEF_BITS-1:0] coef_b2_reg;
    logic signed [COEF_BITS-1:0] coef_a1_reg;
    logic signed [COEF_BITS-1:0] coef_a2_reg;
    logic [GAIN_BITS-1:0]        gain_reg;

    // filter state and working registers
    delay_t                         d1_reg;
    delay_t                         d2_reg;
    delay_t                         acc_reg;
    delay_t                         t1_reg;
    delay_t                         t2_reg;
    logic signed [SAMPLE_BITS-1:0]  x_reg;
    logic signed [SAMPLE_BITS-1:0]  y_reg;
    logic signed [GACC_BITS-1:0]    gacc_reg;
    logic                           m_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  m_data_reg;

    // datapath nets
    ctrl_t                          ctrl;
    logic                           out_busy;
    logic                           s_fire;
    logic signed [MUL_A_BITS-1:0]   mul_a;
    logic signed [MUL_B_BITS-1:0]   mul_b;
    logic signed [PROD_BITS-1:0]    prod;
    delay_t                         prod_sat;
    logic                           add_sub;
    delay_t                         add_a;
    delay_t                         add_b;
    logic signed [DELAY_BITS:0]     add_raw;
    delay_t                         add_sat;
    logic signed [DELAY_BITS:0]     y_shift;
    logic signed [SAMPLE_BITS-1:0]  y_sat;
    logic signed [GACC_BITS-1:0]    gacc_next;
    logic signed [GACC_BITS-1:0]    gsum;
    logic signed [GACC_BITS-1:0]    o_shift;
    logic signed [SAMPLE_BITS-1:0]  o_sat;

    assign out_busy = m_valid_reg && !m_ready;
    assign s_fire   = s_valid && s_ready;

    bnf_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_busy (out_busy),
        .s_ready  (s_ready),
        .ctrl     (ctrl)
    );

    // Multiplier operand select. b0*x is started in the accept cycle, straight
    // from the input port. acc*gain is split: low half zero-extended, high
    // half signed, so the multiplier never exceeds 32x32.
    always_comb begin
        case (ctrl.mul_op)
            MUL_B0X: begin
                mul_a = MUL_A_BITS'(coef_b0_reg);
                mul_b = MUL_B_BITS'(s_sample_in);
            end
            MUL_B1X: begin
                mul_a = MUL_A_BITS'(coef_b1_reg);
                mul_b = MUL_B_BITS'(x_reg);
            end
            MUL_B2X: begin
                mul_a = MUL_A_BITS'(coef_b2_reg);
                mul_b = MUL_B_BITS'(x_reg);
            end
            MUL_A1Y: begin
                mul_a = MUL_A_BITS'(coef_a1_reg);
                mul_b = MUL_B_BITS'(y_reg);
            end
            MUL_A2Y: begin
                mul_a = MUL_A_BITS'(coef_a2_reg);
                mul_b = MUL_B_BITS'(y_reg);
            end
            MUL_GLO: begin
                mul_a = $signed(MUL_A_BITS'({1'b0, acc_reg[ACC_SPLIT-1:0]}));
                mul_b = $signed(MUL_B_BITS'({1'b0, gain_reg}));
            end
            MUL_GHI: begin
                mul_a = MUL_A_BITS'($signed(acc_reg[DELAY_BITS-1:ACC_SPLIT]));
                mul_b = $signed(MUL_B_BITS'({1'b0, gain_reg}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    bnf_mul #(
        .A_BITS (MUL_A_BITS),
        .B_BITS (MUL_B_BITS)
    ) u_mul (
        .aclk (aclk),
        .en   (ctrl.mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // every coefficient product is clipped to the delay range before use
    assign prod_sat = sat_delay(64'(prod));

    // Adder operand select
    always_comb begin
        add_sub = 1'b0;
        case (ctrl.add_op)
            ADD_ACC: begin
                add_a = d1_reg;
                add_b = prod_sat;
            end
            ADD_YRND: begin
                add_a = acc_reg;
                add_b = Y_HALF;
            end
            ADD_T1A: begin
                add_a   = t1_reg;
                add_b   = prod_sat;
                add_sub = 1'b1;
            end
            ADD_T2A: begin
                add_a   = t2_reg;
                add_b   = prod_sat;
                add_sub = 1'b1;
            end
            ADD_T1D: begin
                add_a = t1_reg;
                add_b = d2_reg;
            end
            default: begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    bnf_add u_add (
        .op_sub  (add_sub),
        .op_a    (add_a),
        .op_b    (add_b),
        .sum_raw (add_raw),
        .sum_sat (add_sat)
    );

    // feedback sample y: rounded acc, clamped to the sample range
    assign y_shift = add_raw >>> COEF_FRAC;
    always_comb begin
        if (y_shift > Y_MAX) begin
            y_sat = SAMPLE_BITS'(Y_MAX);
        end else if (y_shift < Y_MIN) begin
            y_sat = SAMPLE_BITS'(Y_MIN);
        end else begin
            y_sat = SAMPLE_BITS'(y_shift);
        end
    end

    // output: acc*gain = (hi*gain << split) + lo*gain, rounding half folded
    // into the low partial product
    assign gacc_next = GACC_BITS'(prod) + G_HALF;
    assign gsum      = (GACC_BITS'(prod) <<< ACC_SPLIT) + gacc_reg;
    assign o_shift   = gsum >>> OUT_SHIFT;
    always_comb begin
        if (o_shift > O_MAX) begin
            o_sat = SAMPLE_BITS'(O_MAX);
        end else if (o_shift < O_MIN) begin
            o_sat = SAMPLE_BITS'(O_MIN);
        end else begin
            o_sat = SAMPLE_BITS'(o_shift);
        end
    end

    // working registers (no reset needed)
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            x_reg <= s_sample_in;
        end
        case (ctrl.add_op)
            ADD_ACC:  acc_reg <= add_sat;
            ADD_YRND: y_reg   <= y_sat;
            ADD_T1A:  t1_reg  <= add_sat;
            ADD_T2A:  t2_reg  <= add_sat;
            ADD_T1D:  t1_reg  <= add_sat;
            default:  ;
        endcase
        if (ctrl.ld_t1_prod) begin
            t1_reg <= prod_sat;
        end
        if (ctrl.ld_t2_prod) begin
            t2_reg <= prod_sat;
        end
        if (ctrl.ld_gacc) begin
            gacc_reg <= gacc_next;
        end
        if (ctrl.commit) begin
            m_data_reg <= o_sat;
        end
    end

    // configuration, delay state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_b0_reg <= COEF_ONE;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
            gain_reg    <= GAIN_ONE;
            d1_reg      <= '0;
            d2_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_B0:   coef_b0_reg <= cfg_wdata[COEF_BITS-1:0];
                    REG_B1:   coef_b1_reg <= cfg_wdata[COEF_BITS-1:0];
                    REG_B2:   coef_b2_reg <= cfg_wdata[COEF_BITS-1:0];
                    REG_A1:   coef_a1_reg <= cfg_wdata[COEF_BITS-1:0];
                    REG_A2:   coef_a2_reg <= cfg_wdata[COEF_BITS-1:0];
                    REG_GAIN: gain_reg    <= cfg_wdata[GAIN_BITS-1:0];
                    default:  ;
                endcase
            end
            // delays advance together with the result beat
            if (ctrl.commit) begin
                d1_reg      <= t1_reg;
                d2_reg      <= t2_reg;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bnf_checker.sv =====
// ----------------------------------------------------------------------------
// bnf_checker
// Port-level assertions for the biquad notch filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bnf_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic signed [SAMPLE_BITS-1:0] m_sample_out
);

    // block stays busy while the sequencer works through a sample after its beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready ##1 !s_ready ##1 !s_ready ##1 !s_ready
                                  ##1 !s_ready ##1 !s_ready ##1 !s_ready)
        else $error("s_ready returned before the sample finished");

    // a fresh result appears only after its sample beat has run through the sequencer
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 8))
        else $error("result beat without matching sample beat");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_sample_out)))
        else $error("stalled result dropped or changed");

    // result leaves only through a handshake
    a_out_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("m_valid fell without m_ready");

endmodule

bind biquad_notch_filter bnf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bnf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out)
);

`default_nettype wire
